// ===== rtl/mttc_pkg.sv =====
// ----------------------------------------------------------------------------
// mttc_pkg
// shared types, codes and constants of the mixed type trigger comparator
// ----------------------------------------------------------------------------
package mttc_pkg;

	localparam int unsigned INT_WIDTH_DEF = 64;

	typedef enum logic [2:0] {
		REL_EQ = 3'd0,
		REL_NE = 3'd1,
		REL_GT = 3'd2,
		REL_GE = 3'd3,
		REL_LT = 3'd4,
		REL_LE = 3'd5
	} rel_t;

	typedef enum logic [1:0] {
		TYPE_FLOAT    = 2'd0,
		TYPE_SIGNED   = 2'd1,
		TYPE_UNSIGNED = 2'd2,
		TYPE_INVALID  = 2'd3
	} op_type_t;

	localparam logic [1:0] ADDR_RELATION    = 2'd0;
	localparam logic [1:0] ADDR_TYPE_FIRST  = 2'd1;
	localparam logic [1:0] ADDR_TYPE_SECOND = 2'd2;

	// control bundle for the relation logic
	typedef struct packed {
		logic        invalid;
		logic        use_float;
		logic        any_nan;
		logic [2:0]  relation;
	} cmp_ctl_t;

endpackage

// ===== rtl/mttc_to_key.sv =====
// ----------------------------------------------------------------------------
// mttc_to_key
// maps one operand to an order-preserving unsigned key (float or integer)
// ----------------------------------------------------------------------------
module mttc_to_key
	import mttc_pkg::*;
#(
	parameter int unsigned INT_WIDTH = INT_WIDTH_DEF
) (
	input  logic [63:0]          value,
	input  logic [1:0]           op_type,
	input  logic                 signed_mode,
	output logic [31:0]          float_key,
	output logic                 is_nan,
	output logic [INT_WIDTH-1:0] int_key
);

	logic [INT_WIDTH-1:0] raw;
	logic                 neg;
	logic [INT_WIDTH-1:0] mag;
	logic [31:0]          fbits;
	logic [31:0]          conv;
	logic [6:0]           msb;
	logic [63:0]          mag64;
	logic [63:0]          norm;
	logic [23:0]          mant;
	logic                 guard;
	logic                 sticky;
	logic [24:0]          mrnd;
	logic [7:0]           expo;

	assign raw = value[INT_WIDTH-1:0];
	assign neg = (op_type == TYPE_SIGNED) && raw[INT_WIDTH-1];
	assign mag = neg ? (~raw + 1'b1) : raw;
	assign mag64 = 64'(mag);

	always_comb begin
		msb = 7'd0;
		for (int i = 0; i < 64; i++) begin
			if (mag64[i]) begin
				msb = 7'(i);
			end
		end
	end

	assign norm   = mag64 << (7'd63 - msb);
	assign mant   = norm[63:40];
	assign guard  = norm[39];
	assign sticky = |norm[38:0];
	assign mrnd   = {1'b0, mant} + 25'(guard && (sticky || mant[0]));

	always_comb begin
		expo = 8'(msb) + 8'd127;
		if (mrnd[24]) begin
			expo = expo + 8'd1;
		end
		if (mag64 == 64'd0) begin
			conv = 32'd0;
		end else begin
			conv = {neg, expo, mrnd[24] ? mrnd[23:1] : mrnd[22:0]};
			conv[22:0] = mrnd[24] ? 23'd0 : mrnd[22:0];
		end
	end

	assign fbits  = (op_type == TYPE_FLOAT) ? value[31:0] : conv;
	assign is_nan = (fbits[30:23] == 8'hFF) && (fbits[22:0] != 23'd0);

	always_comb begin
		if (fbits[30:0] == 31'd0) begin
			float_key = 32'h8000_0000;
		end else if (fbits[31]) begin
			float_key = ~fbits;
		end else begin
			float_key = fbits | 32'h8000_0000;
		end
	end

	assign int_key = signed_mode ? {~raw[INT_WIDTH-1], raw[INT_WIDTH-2:0]} : raw;

endmodule

// ===== rtl/mttc_relate.sv =====
// ----------------------------------------------------------------------------
// mttc_relate
// applies the configured relation to two keys
// ----------------------------------------------------------------------------
module mttc_relate
	import mttc_pkg::*;
#(
	parameter int unsigned INT_WIDTH = INT_WIDTH_DEF
) (
	input  cmp_ctl_t             ctl,
	input  logic [31:0]          fa,
	input  logic [31:0]          fb,
	input  logic [INT_WIDTH-1:0] ia,
	input  logic [INT_WIDTH-1:0] ib,
	output logic                 met
);

	logic eq;
	logic gt;

	assign eq = ctl.use_float ? (fa == fb) : (ia == ib);
	assign gt = ctl.use_float ? (fa > fb) : (ia > ib);

	always_comb begin
		if (ctl.invalid) begin
			met = 1'b0;
		end else if (ctl.use_float && ctl.any_nan) begin
			met = (ctl.relation == REL_NE);
		end else begin
			case (ctl.relation)
				REL_EQ:  met = eq;
				REL_NE:  met = !eq;
				REL_GT:  met = gt;
				REL_GE:  met = gt || eq;
				REL_LT:  met = !gt && !eq;
				REL_LE:  met = !gt;
				default: met = 1'b0;
			endcase
		end
	end

endmodule

// ===== rtl/mixed_type_trigger_comparator.sv =====
// ----------------------------------------------------------------------------
// mixed_type_trigger_comparator
// compares two operands of configurable type under a configurable relation
// ----------------------------------------------------------------------------
// One transaction per clock: busy is always low, so start is taken every
// cycle. Operands are captured in the input register at the accepting edge,
// converted to keys and compared in the following cycle, and the outcome is
// captured in the result register at the next edge; done and condition_met
// are valid in the cycle after that, one cycle long. The receiver cannot
// stall, and results are never held back.
module mixed_type_trigger_comparator
	import mttc_pkg::*;
#(
	parameter int unsigned INT_WIDTH = INT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] value_first,
	input  logic [63:0] value_second,
	output logic        done,
	output logic        condition_met
);

	logic [2:0] relation_q;
	logic [1:0] type_first_q;
	logic [1:0] type_second_q;
	logic       wr;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relation_q    <= REL_EQ;
			type_first_q  <= TYPE_UNSIGNED;
			type_second_q <= TYPE_UNSIGNED;
		end else if (wr) begin
			case (paddr[3:2])
				ADDR_RELATION:    relation_q    <= pwdata[2:0];
				ADDR_TYPE_FIRST:  type_first_q  <= pwdata[1:0];
				ADDR_TYPE_SECOND: type_second_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			ADDR_RELATION:    prdata = {29'd0, relation_q};
			ADDR_TYPE_FIRST:  prdata = {30'd0, type_first_q};
			ADDR_TYPE_SECOND: prdata = {30'd0, type_second_q};
			default:          prdata = 32'd0;
		endcase
	end

	// input register
	logic [63:0] a_s1;
	logic [63:0] b_s1;
	logic        v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= value_first;
		b_s1 <= value_second;
	end

	logic                 signed_mode;
	logic [31:0]          fa;
	logic [31:0]          fb;
	logic                 nan_a;
	logic                 nan_b;
	logic [INT_WIDTH-1:0] ia;
	logic [INT_WIDTH-1:0] ib;
	cmp_ctl_t             ctl;
	logic                 met;

	assign signed_mode = !(type_first_q == TYPE_UNSIGNED && type_second_q == TYPE_UNSIGNED);

	mttc_to_key #(.INT_WIDTH(INT_WIDTH)) u_key_a (
		.value(a_s1), .op_type(type_first_q), .signed_mode(signed_mode),
		.float_key(fa), .is_nan(nan_a), .int_key(ia)
	);

	mttc_to_key #(.INT_WIDTH(INT_WIDTH)) u_key_b (
		.value(b_s1), .op_type(type_second_q), .signed_mode(signed_mode),
		.float_key(fb), .is_nan(nan_b), .int_key(ib)
	);

	always_comb begin
		ctl.invalid   = (type_first_q == TYPE_INVALID) || (type_second_q == TYPE_INVALID);
		ctl.use_float = (type_first_q == TYPE_FLOAT) || (type_second_q == TYPE_FLOAT);
		ctl.any_nan   = nan_a || nan_b;
		ctl.relation  = relation_q;
	end

	mttc_relate #(.INT_WIDTH(INT_WIDTH)) u_relate (
		.ctl(ctl), .fa(fa), .fb(fb), .ia(ia), .ib(ib), .met(met)
	);

	// result register
	logic done_q;
	logic met_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		met_q <= met;
	end

	assign done          = done_q;
	assign condition_met = met_q;

endmodule

// ===== rtl/mttc_checker.sv =====
// ----------------------------------------------------------------------------
// mttc_checker
// port-level checks of the mixed type trigger comparator
// ----------------------------------------------------------------------------
module mttc_checker
	import mttc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       pready
);

	// each accepted transaction yields a done strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("missing result strobe");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(start, 2) && $past(arst_n, 2) |-> !done)
		else $error("result strobe without transaction");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind mixed_type_trigger_comparator mttc_checker u_mttc_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.pready(pready)
);
